// ===== hdl/fba_pkg.sv =====
// Shared constants, types and helpers for the fixed block free list allocator.
package fba_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = 9;
    localparam int END_BIT    = 8;
    localparam int BS_W       = 9;
    localparam int OFF_W      = 16;
    localparam int OUT_IDX_W  = 8;
    localparam int STATUS_W   = 3;
    localparam int PROD_W     = OUT_IDX_W + BS_W;
    localparam int DIV_STEPS  = OFF_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [BS_W-1:0]   BS_RESET = BS_W'(8);
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(1) << END_BIT;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_SIZE  = 3'd2,
        STAT_ALIGN = 3'd3,
        STAT_RANGE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_DIV,
        S_FREE,
        S_DONE
    } t_state;

    function automatic logic [LINK_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(NUM_BLOCKS - 1)) begin
            return END_MARK;
        end
        return LINK_W'(idx) + LINK_W'(1);
    endfunction

endpackage

// ===== hdl/fba_req_if.sv =====
// Request channel carrying allocate and free items.
interface fba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [fba_pkg::BS_W-1:0]     request_size;
    logic [fba_pkg::OFF_W-1:0]    byte_offset;

    modport source (output valid, output func, output request_size, output byte_offset,
                    input ready);
    modport sink   (input valid, input func, input request_size, input byte_offset,
                    output ready);
endinterface

// ===== hdl/fba_rsp_if.sv =====
// Response channel carrying one result item per request.
interface fba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [fba_pkg::OUT_IDX_W-1:0]   block_index;
    logic [fba_pkg::OFF_W-1:0]       block_offset;
    logic [fba_pkg::STATUS_W-1:0]    status;
    logic                            pool_full;

    modport source (output valid, output block_index, output block_offset, output status,
                    output pool_full, input ready);
    modport sink   (input valid, input block_index, input block_offset, input status,
                    input pool_full, output ready);
endinterface

// ===== hdl/fba_cfg_if.sv =====
// Configuration write channel for the block size register.
interface fba_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [fba_pkg::BS_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fixed_block_free_list_allocator_core.sv =====
// Fixed block free list allocator: link table, head register and iterative divider.
// Allocate: taken only in idle, then the check, alloc and done states lead to the result register.
// Free: 16 divider steps (one quotient bit per cycle), then the free and done states.
// Size errors, an empty pool on allocate and a zero block size on free go from check to done.
// A result stalled at the output holds the next item in its last step until the register frees.
// Reset sets block size 8 and head 0; valid bits present the initial chain with no clearing pass.
module fixed_block_free_list_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fba_req_if.sink     i_req,
    fba_rsp_if.source   o_rsp,
    fba_cfg_if.sink     i_cfg
);

    fba_pkg::t_state                    r_state, n_state;
    logic                               r_func, n_func;
    logic [fba_pkg::BS_W-1:0]           r_req_size, n_req_size;
    logic [fba_pkg::BS_W-1:0]           r_bs;
    logic [fba_pkg::LINK_W-1:0]         r_head, n_head;
    logic [fba_pkg::OFF_W-1:0]          r_div_q, n_div_q;
    logic [fba_pkg::BS_W-1:0]           r_div_r, n_div_r;
    logic [fba_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [fba_pkg::OUT_IDX_W-1:0]      r_res_idx, n_res_idx;
    logic [fba_pkg::OFF_W-1:0]          r_res_off, n_res_off;
    fba_pkg::t_status                   r_res_status, n_res_status;
    logic                               r_out_valid, n_out_valid;
    logic [fba_pkg::OUT_IDX_W-1:0]      r_out_idx, n_out_idx;
    logic [fba_pkg::OFF_W-1:0]          r_out_off, n_out_off;
    fba_pkg::t_status                   r_out_status, n_out_status;
    logic                               r_out_full, n_out_full;
    logic [fba_pkg::NUM_BLOCKS-1:0]     r_lvalid;
    logic [fba_pkg::LINK_W-1:0]         r_mem_q;
    logic                               r_rd_valid;

    logic [fba_pkg::LINK_W-1:0]         link_mem [fba_pkg::NUM_BLOCKS];

    logic                               rd_en;
    logic                               wr_en;
    logic [fba_pkg::IDX_W-1:0]          head_idx;
    logic [fba_pkg::IDX_W-1:0]          slot;
    logic [fba_pkg::BS_W:0]             div_trial;
    logic [fba_pkg::BS_W+1:0]           div_diff;
    logic [fba_pkg::PROD_W-1:0]         prod;

    assign head_idx  = r_head[fba_pkg::IDX_W-1:0];
    assign slot      = r_div_q[fba_pkg::IDX_W-1:0];
    assign div_trial = {r_div_r, r_div_q[fba_pkg::OFF_W-1]};
    assign div_diff  = {1'b0, div_trial} - (fba_pkg::BS_W+2)'(r_bs);
    assign prod      = fba_pkg::PROD_W'(fba_pkg::OUT_IDX_W'(head_idx))
                     * fba_pkg::PROD_W'(r_bs);

    assign i_req.ready        = (r_state == fba_pkg::S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.block_index  = r_out_idx;
    assign o_rsp.block_offset = r_out_off;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.pool_full    = r_out_full;

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_req_size   = r_req_size;
        n_head       = r_head;
        n_div_q      = r_div_q;
        n_div_r      = r_div_r;
        n_cnt        = r_cnt;
        n_res_idx    = r_res_idx;
        n_res_off    = r_res_off;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_idx    = r_out_idx;
        n_out_off    = r_out_off;
        n_out_status = r_out_status;
        n_out_full   = r_out_full;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fba_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_func     = i_req.func;
                    n_req_size = i_req.request_size;
                    n_div_q    = i_req.byte_offset;
                    n_div_r    = '0;
                    n_cnt      = '0;
                    n_state    = fba_pkg::S_CHECK;
                end
            end
            fba_pkg::S_CHECK: begin
                n_res_idx    = '0;
                n_res_off    = '0;
                n_res_status = fba_pkg::STAT_OK;
                if (r_req_size != r_bs) begin
                    n_res_status = fba_pkg::STAT_SIZE;
                    n_state      = fba_pkg::S_DONE;
                end else if (r_func == fba_pkg::FUNC_ALLOC) begin
                    if (r_head[fba_pkg::END_BIT]) begin
                        n_res_status = fba_pkg::STAT_EMPTY;
                        n_state      = fba_pkg::S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = fba_pkg::S_ALLOC;
                    end
                end else if (r_bs == '0) begin
                    n_res_status = fba_pkg::STAT_ALIGN;
                    n_state      = fba_pkg::S_DONE;
                end else begin
                    n_state = fba_pkg::S_DIV;
                end
            end
            fba_pkg::S_ALLOC: begin
                n_head    = r_rd_valid ? r_mem_q : fba_pkg::link_reset(head_idx);
                n_res_idx = fba_pkg::OUT_IDX_W'(head_idx);
                n_res_off = prod[fba_pkg::OFF_W-1:0];
                n_state   = fba_pkg::S_DONE;
            end
            fba_pkg::S_DIV: begin
                if (div_diff[fba_pkg::BS_W+1]) begin
                    n_div_r = div_trial[fba_pkg::BS_W-1:0];
                    n_div_q = {r_div_q[fba_pkg::OFF_W-2:0], 1'b0};
                end else begin
                    n_div_r = div_diff[fba_pkg::BS_W-1:0];
                    n_div_q = {r_div_q[fba_pkg::OFF_W-2:0], 1'b1};
                end
                n_cnt = r_cnt + fba_pkg::CNT_W'(1);
                if (r_cnt == fba_pkg::CNT_W'(fba_pkg::DIV_STEPS - 1)) begin
                    n_state = fba_pkg::S_FREE;
                end
            end
            fba_pkg::S_FREE: begin
                if (r_div_r != '0) begin
                    n_res_status = fba_pkg::STAT_ALIGN;
                end else if (r_div_q >= fba_pkg::OFF_W'(fba_pkg::NUM_BLOCKS)) begin
                    n_res_status = fba_pkg::STAT_RANGE;
                end else begin
                    wr_en  = 1'b1;
                    n_head = fba_pkg::LINK_W'(slot);
                end
                n_state = fba_pkg::S_DONE;
            end
            fba_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_res_idx;
                    n_out_off    = r_res_off;
                    n_out_status = r_res_status;
                    n_out_full   = r_head[fba_pkg::END_BIT];
                    n_state      = fba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fba_pkg::S_IDLE;
            r_head      <= '0;
            r_bs        <= fba_pkg::BS_RESET;
            r_out_valid <= 1'b0;
            r_lvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_bs <= i_cfg.data;
            end
            if (wr_en) begin
                r_lvalid[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_req_size   <= n_req_size;
        r_div_q      <= n_div_q;
        r_div_r      <= n_div_r;
        r_cnt        <= n_cnt;
        r_res_idx    <= n_res_idx;
        r_res_off    <= n_res_off;
        r_res_status <= n_res_status;
        r_out_idx    <= n_out_idx;
        r_out_off    <= n_out_off;
        r_out_status <= n_out_status;
        r_out_full   <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            link_mem[slot] <= r_head;
        end
        if (rd_en) begin
            r_mem_q    <= link_mem[head_idx];
            r_rd_valid <= r_lvalid[head_idx];
        end
    end

endmodule

// ===== tb/tb_fixed_block_free_list_allocator_core.sv =====
// Self-checking testbench for the fixed block free list allocator core.
module tb_fixed_block_free_list_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PICK_BS = -1;
    localparam int NUM_PHASES = 7;
    localparam int PHASE_BS [NUM_PHASES] = '{4, 256, 0, 511, PICK_BS, PICK_BS, 8};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{300, 80, 40, 40, 60, 60, 50};
    localparam int PHASE_ALLOC [NUM_PHASES] = '{98, 20, 50, 50, 50, 50, 50};
    localparam int PHASE_NOISE [NUM_PHASES] = '{5, 15, 20, 15, 20, 20, 20};

    typedef struct packed {
        logic [fba_pkg::OUT_IDX_W-1:0] idx;
        logic [fba_pkg::OFF_W-1:0]     boff;
        fba_pkg::t_status              status;
        logic                          full;
    } t_grant;

    typedef struct packed {
        logic                       op;
        logic [fba_pkg::BS_W-1:0]   size;
        logic [fba_pkg::OFF_W-1:0]  off;
        logic                       typed;
        t_grant                     want;
    } t_script_row;

    localparam int SCRIPT_LEN = 20;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'hFFFF, 1'b1, '{8'd1, 16'd8, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd7, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_SIZE, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'h1FF, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_SIZE, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd0, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_SIZE, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd8, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'd0, 1'b1, '{8'd1, 16'd8, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd9, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_ALIGN, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'hFFFF, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_ALIGN, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd2048, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_RANGE, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'hFFF8, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_RANGE, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'h1FF, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_SIZE, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'h100, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_SIZE, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd8, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'd0, 1'b1, '{8'd1, 16'd8, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'd0, 1'b1, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'd0, 1'b0, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_FREE, 9'd8, 16'd16, 1'b0, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}},
        '{fba_pkg::FUNC_ALLOC, 9'd8, 16'h5555, 1'b0, '{8'd0, 16'd0, fba_pkg::STAT_OK, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    fba_req_if req_if ();
    fba_rsp_if rsp_if ();
    fba_cfg_if cfg_if ();

    fixed_block_free_list_allocator_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [fba_pkg::BS_W-1:0]   model_bs;
    logic [fba_pkg::LINK_W-1:0] model_head;
    logic [fba_pkg::LINK_W-1:0] model_link [fba_pkg::NUM_BLOCKS];
    t_grant            grants_due [$];
    logic [7:0]        held [$];
    int                burst_left = 0;
    int                errors = 0;
    int                quiet_cycles = 0;
    logic [7:0]        stall_pat = 8'hFF;
    int                stall_cnt = 0;
    t_grant            got;
    t_grant            want;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_grant pool_step(input logic op, input logic [fba_pkg::BS_W-1:0] sz,
                                         input logic [fba_pkg::OFF_W-1:0] off);
        t_grant      g;
        int unsigned bs;
        int unsigned idx;
        int unsigned slot;
        bs = model_bs;
        g = '0;
        g.status = fba_pkg::STAT_OK;
        if (sz != model_bs) begin
            g.status = fba_pkg::STAT_SIZE;
        end else if (op == fba_pkg::FUNC_ALLOC) begin
            if (model_head[fba_pkg::END_BIT]) begin
                g.status = fba_pkg::STAT_EMPTY;
            end else begin
                idx = model_head[7:0];
                model_head = model_link[idx];
                g.idx = idx[7:0];
                g.boff = 16'(idx * bs);
            end
        end else if (bs == 0 || int'(off) % bs != 0) begin
            g.status = fba_pkg::STAT_ALIGN;
        end else if (int'(off) >= bs * fba_pkg::NUM_BLOCKS) begin
            g.status = fba_pkg::STAT_RANGE;
        end else begin
            slot = int'(off) / bs;
            model_link[slot] = model_head;
            model_head = fba_pkg::LINK_W'(slot);
        end
        g.full = model_head[fba_pkg::END_BIT];
        return g;
    endfunction

    task automatic issue(input logic op, input logic [fba_pkg::BS_W-1:0] sz,
                         input logic [fba_pkg::OFF_W-1:0] off, input logic typed,
                         input t_grant fixed);
        t_grant g;
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.func <= op;
        req_if.request_size <= sz;
        req_if.byte_offset <= off;
        do @(posedge clk); while (!req_if.ready);
        g = pool_step(op, sz, off);
        grants_due = {grants_due, (typed ? fixed : g)};
        if (g.status == fba_pkg::STAT_OK) begin
            if (op == fba_pkg::FUNC_ALLOC) begin
                held = {held, g.idx};
            end else begin
                for (int i = 0; i < held.size(); i++) begin
                    if (held[i] == model_head[7:0]) begin
                        held.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic write_block_size(input int v);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (grants_due.size() != 0) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= fba_pkg::BS_W'(v);
        do @(posedge clk); while (!cfg_if.ready);
        model_bs = fba_pkg::BS_W'(v);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_item(input int alloc_pct, input int noise_pct, input bit dbl_ok);
        int unsigned               bs;
        int unsigned               kind;
        logic                      op;
        logic [fba_pkg::BS_W-1:0]  sz;
        logic [fba_pkg::OFF_W-1:0] off;
        bs = model_bs;
        op = fba_pkg::FUNC_ALLOC;
        sz = model_bs;
        off = 16'($urandom);
        if ($urandom_range(99) < noise_pct) begin
            kind = $urandom_range(dbl_ok ? 3 : 2);
            if (kind == 0) begin
                op = 1'($urandom);
                sz = 9'($urandom);
                if (sz == model_bs) begin
                    sz ^= 9'(1 << $urandom_range(8));
                end
            end else if (kind == 3) begin
                op = fba_pkg::FUNC_FREE;
                off = 16'($urandom_range(255) * bs);
            end else begin
                op = fba_pkg::FUNC_FREE;
                if (kind == 2 && bs != 0 && bs < 256) begin
                    off = 16'($urandom_range(65535 / bs, 256) * bs);
                end else if (bs != 0 && int'(off) % bs == 0) begin
                    off ^= 16'd1;
                end
            end
        end else if (held.size() != 0 && $urandom_range(99) >= alloc_pct) begin
            op = fba_pkg::FUNC_FREE;
            off = 16'(held[$urandom_range(held.size() - 1)] * bs);
        end
        issue(op, sz, off, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (stall_cnt == 0) begin
            stall_cnt <= $urandom_range(16, 80);
            stall_pat <= ($urandom_range(3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
            stall_cnt <= stall_cnt - 1;
            stall_pat <= {stall_pat[0], stall_pat[7:1]};
        end
        rsp_if.ready <= stall_pat[0];
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.block_index, rsp_if.block_offset,
                    fba_pkg::t_status'(rsp_if.status), rsp_if.pool_full};
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
            end else begin
                want = grants_due.pop_front();
                check_field("block_index", want.idx, got.idx);
                check_field("block_offset", want.boff, got.boff);
                check_field("status", want.status, got.status);
                check_field("pool_full", want.full, got.full);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fixed_block_free_list_allocator_core test failed");
            $finish;
        end
    end

    initial begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func <= fba_pkg::FUNC_ALLOC;
        req_if.request_size <= '0;
        req_if.byte_offset <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        model_bs = fba_pkg::BS_RESET;
        model_head = '0;
        for (int i = 0; i < fba_pkg::NUM_BLOCKS; i++) begin
            model_link[i] = (i == fba_pkg::NUM_BLOCKS - 1) ? fba_pkg::END_MARK
                                                           : fba_pkg::LINK_W'(i + 1);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            issue(SCRIPT[r].op, SCRIPT[r].size, SCRIPT[r].off, SCRIPT[r].typed, SCRIPT[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_block_size((PHASE_BS[p] == PICK_BS) ? $urandom_range(4, 256) : PHASE_BS[p]);
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                random_item(PHASE_ALLOC[p], PHASE_NOISE[p], p == NUM_PHASES - 1);
            end
        end

        req_if.valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("fixed_block_free_list_allocator_core test passed");
        end else begin
            $display("fixed_block_free_list_allocator_core test failed");
        end
        $finish;
    end

endmodule
